// ===== rtl/autorange_light_frequency_meter_defines.svh =====
// assertion macros shared by the frequency meter rtl
// no dependencies; included by modules that carry assertions
`ifndef AUTORANGE_LIGHT_FREQUENCY_METER_DEFINES_SVH
`define AUTORANGE_LIGHT_FREQUENCY_METER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ALFM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alfm assertion failed");

// next-cycle implication, disabled in reset
`define ALFM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alfm assertion failed");

`endif

// ===== rtl/alfm_pkg.sv =====
// shared types and constants of the light frequency meter
// no dependencies
package alfm_pkg;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_NORM  = 8'b0000_1000,
    S_SQR   = 8'b0001_0000,
    S_TERM  = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  localparam logic [1:0] CMD_POLL   = 2'd0;
  localparam logic [1:0] CMD_PERIOD = 2'd1;
  localparam logic [1:0] CMD_GATE   = 2'd2;

  localparam logic [1:0] REG_CLOCK_HZ   = 2'd0;
  localparam logic [1:0] REG_SQ_OFFSET  = 2'd1;
  localparam logic [1:0] REG_UP_SWITCH  = 2'd2;
  localparam logic [1:0] REG_DOWN_SWITCH = 2'd3;

  localparam logic [27:0] CLOCK_HZ_RST = 28'd48000000;
  localparam logic [19:0] UP_SWITCH_RST = 20'd1500;
  localparam logic [19:0] DOWN_SWITCH_RST = 20'd1000;

  // 2.5*log10(2) in q24
  localparam logic [23:0] LOG_K_Q24 = 24'd12626113;
  localparam logic signed [14:0] SKY_ZERO_Q8 = 15'sd5632;
  localparam logic signed [16:0] SKY_MAX = 17'sd16383;
  localparam logic signed [16:0] SKY_MIN = -17'sd16384;
  // ceil(2^21/10), exact floor division by ten for values below 2^18
  localparam logic [17:0] TENTH_RECIP = 18'd209716;
  localparam logic [9:0] SLOW_NUM = 10'd1000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/autorange_light_frequency_meter.sv =====
// top level of the auto-ranging light frequency meter
// uses alfm_pkg, alfm_div and the assertion macro header
//
// usage:
//  input channel (in_valid/in_ready) takes one item: command, sample_value,
//  now_ms. command selects poll, period capture or gate count.
//  output channel (out_valid/out_ready) returns exactly one item per input:
//  range_mode, frequency_q12, sensor_seen, sky_brightness_q8, frequency_updated.
//  the block works on one item at a time; in_ready is high only when idle.
//  a poll with zero frequency goes from the check straight to the output; an
//  item that divides first runs the shared restoring divider (one bit per
//  cycle); a nonzero frequency then takes a normalizing shift and the log
//  squaring in one 32x32 multiplier, then the scale multiply and offset.
//  the result waits in the output registers while out_ready is low; no new
//  item is taken until it is accepted.
//  configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
//  are meant for idle time only.
//  reset (rst, synchronous) restores register defaults and clears the fsm, mode, averages, frequency and flags.
module autorange_light_frequency_meter
  import alfm_pkg::*;
#(
  parameter int PERIOD_AVERAGE = 11,
  parameter int GATE_AVERAGE   = 5,
  parameter int SLOW_LIMIT_MS  = 1000,
  parameter int FREQ_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [27:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [31:0]        sample_value,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               range_mode,
  output logic [31:0]        frequency_q12,
  output logic               sensor_seen,
  output logic signed [14:0] sky_brightness_q8,
  output logic               frequency_updated
);

  localparam int F  = FREQ_FRAC_BITS;
  localparam int DW = 33 + F;

  state_t state;

  logic [27:0] clock_hz;
  logic [8:0]  sq_offset_tenths;
  logic [19:0] up_switch_hz;
  logic [19:0] down_switch_hz;
  logic [13:0] off_q8;

  logic        mode;
  logic [31:0] sample_sum;
  logic [3:0]  sample_count;
  logic [31:0] last_capture_ms;
  logic        slow_timer_flag;
  logic [31:0] frequency;
  logic        seen;
  logic        updated;
  logic        check;
  logic [31:0] now_l;
  logic signed [14:0] sky;

  logic          div_go;
  logic [DW-1:0] div_dvd;
  logic [31:0]   div_dvs;
  logic [DW-1:0] div_q;
  div_status_t   div_st;

  logic [31:0] m;
  logic [4:0]  e;
  logic [15:0] frac;
  logic [3:0]  sq_cnt;
  logic [44:0] k_prod;
  logic        l_neg;

  // idle-time decision terms
  logic [31:0]   dt;
  logic [31:0]   base_sum;
  logic [3:0]    base_cnt;
  logic [32:0]   add_sum;
  logic [31:0]   new_sum;
  logic [3:0]    new_cnt;
  logic [31:0]   ck_prod;
  logic [DW-1:0] per_dvd;
  logic [DW-1:0] gate_dvd;
  logic [DW-1:0] slow_dvd;

  always_comb begin
    dt       = now_ms - last_capture_ms;
    base_sum = (!mode && slow_timer_flag) ? 32'd0 : sample_sum;
    base_cnt = (!mode && slow_timer_flag) ? 4'd0 : sample_count;
    add_sum  = {1'b0, base_sum} + {1'b0, sample_value};
    new_sum  = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
    new_cnt  = base_cnt + 4'd1;
    ck_prod  = {4'b0, clock_hz} * {28'b0, new_cnt};
    per_dvd  = (DW'(ck_prod) << F) + DW'(new_sum >> 1);
    gate_dvd = (DW'(new_sum) << F) + DW'(new_cnt >> 1);
    slow_dvd = (DW'(SLOW_NUM) << F) + DW'(dt >> 1);
  end

  // squaring step of the log
  logic [63:0] sq_full;
  logic [32:0] sq_sh;
  assign sq_full = {32'b0, m} * {32'b0, m};
  assign sq_sh   = sq_full[63:31];

  // log2 minus the fraction scale, signed
  logic signed [21:0] l_val;
  logic [20:0]        l_mag;
  assign l_val = $signed({1'b0, e, frac}) - 22'sd1 * $signed(22'(F) << 16);
  assign l_mag = l_val[21] ? 21'(-l_val) : l_val[20:0];

  logic [13:0]        term;
  logic signed [16:0] sky_s;
  logic [45:0]        k_round;
  assign k_round = {1'b0, k_prod} + 46'h0_0080_0000_00;
  assign term    = k_round[45:32];
  assign sky_s   = l_neg ? $signed({3'b0, off_q8}) + $signed({3'b0, term})
                         : $signed({3'b0, off_q8}) - $signed({3'b0, term});

  logic [16:0] off_x;
  logic [34:0] off_p;
  assign off_x = {sq_offset_tenths, 8'b0} + 17'd5;
  assign off_p = {18'b0, off_x} * {17'b0, TENTH_RECIP};

  logic [DW-1:0] up_lim;
  logic [DW-1:0] down_lim;
  assign up_lim   = DW'(up_switch_hz) << F;
  assign down_lim = DW'(down_switch_hz) << F;

  alfm_div #(.DW(DW), .VW(32)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      clock_hz         <= CLOCK_HZ_RST;
      sq_offset_tenths <= '0;
      up_switch_hz     <= UP_SWITCH_RST;
      down_switch_hz   <= DOWN_SWITCH_RST;
      mode             <= 1'b0;
      sample_sum       <= '0;
      sample_count     <= '0;
      last_capture_ms  <= '0;
      slow_timer_flag  <= 1'b0;
      frequency        <= '0;
      seen             <= 1'b0;
      div_go           <= 1'b0;
      updated          <= 1'b0;
      check            <= 1'b0;
    end else begin
      div_go <= 1'b0;
      off_q8 <= off_p[34:21];
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOCK_HZ:    clock_hz <= cfg_data;
          REG_SQ_OFFSET:   sq_offset_tenths <= cfg_data[8:0];
          REG_UP_SWITCH:   up_switch_hz <= cfg_data[19:0];
          REG_DOWN_SWITCH: down_switch_hz <= cfg_data[19:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            now_l   <= now_ms;
            updated <= 1'b0;
            check   <= 1'b1;
            state   <= S_CHECK;
            if (!mode) begin
              if (command == CMD_PERIOD) begin
                seen            <= 1'b1;
                last_capture_ms <= now_ms;
                if (dt > 32'(SLOW_LIMIT_MS)) begin
                  // slow light: timer fallback, capture dropped
                  slow_timer_flag <= 1'b1;
                  div_dvd <= slow_dvd;
                  div_dvs <= dt;
                  div_go  <= 1'b1;
                  check   <= 1'b0;
                  updated <= 1'b1;
                  state   <= S_DIV;
                end else begin
                  slow_timer_flag <= 1'b0;
                  if (new_cnt >= 4'(PERIOD_AVERAGE)) begin
                    sample_sum   <= '0;
                    sample_count <= '0;
                    updated      <= 1'b1;
                    if (new_sum != 32'd0) begin
                      div_dvd <= per_dvd;
                      div_dvs <= new_sum;
                      div_go  <= 1'b1;
                      state   <= S_DIV;
                    end else begin
                      frequency <= '0;
                    end
                  end else begin
                    sample_sum   <= new_sum;
                    sample_count <= new_cnt;
                  end
                end
              end
            end else if (command == CMD_GATE) begin
              seen <= 1'b1;
              if (new_cnt >= 4'(GATE_AVERAGE) && new_cnt != 4'd0) begin
                sample_sum   <= '0;
                sample_count <= '0;
                updated      <= 1'b1;
                div_dvd      <= gate_dvd;
                div_dvs      <= {28'b0, new_cnt};
                div_go       <= 1'b1;
                state        <= S_DIV;
              end else begin
                sample_sum   <= new_sum;
                sample_count <= new_cnt;
              end
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            frequency <= (div_q[DW-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!mode) begin
            if (check && DW'(frequency) > up_lim) begin
              mode         <= 1'b1;
              sample_sum   <= '0;
              sample_count <= '0;
            end
          end else if (DW'(frequency) < down_lim) begin
            mode            <= 1'b0;
            last_capture_ms <= now_l;
            sample_sum      <= '0;
            sample_count    <= '0;
          end
          m <= frequency;
          e <= 5'd31;
          if (frequency == 32'd0) begin
            sky   <= SKY_ZERO_Q8;
            state <= S_OUT;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // shift up to the leading one
          if (m[31]) begin
            frac   <= '0;
            sq_cnt <= '0;
            state  <= S_SQR;
          end else begin
            m <= {m[30:0], 1'b0};
            e <= e - 5'd1;
          end
        end
        S_SQR: begin
          frac   <= {frac[14:0], sq_sh[32]};
          m      <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
          sq_cnt <= sq_cnt + 4'd1;
          if (sq_cnt == 4'd15) begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          k_prod <= {24'b0, l_mag} * {21'b0, LOG_K_Q24};
          l_neg  <= l_val[21];
          state  <= S_SUM;
        end
        S_SUM: begin
          if (sky_s > SKY_MAX) begin
            sky <= 15'(SKY_MAX);
          end else if (sky_s < SKY_MIN) begin
            sky <= 15'(SKY_MIN);
          end else begin
            sky <= sky_s[14:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state == S_IDLE);
  assign out_valid         = (state == S_OUT);
  assign range_mode        = mode;
  assign frequency_q12     = frequency;
  assign sensor_seen       = seen;
  assign sky_brightness_q8 = sky;
  assign frequency_updated = updated;

`include "autorange_light_frequency_meter_defines.svh"

  `ALFM_ASSERT_IMP(a_ready_excl, in_ready, !out_valid)
  `ALFM_ASSERT_IMP(a_done_in_div, div_st.done, state == S_DIV)
  `ALFM_ASSERT_NXT(a_out_ret, out_valid && out_ready, in_ready)
  `ALFM_ASSERT_IMP(a_sky_zero, out_valid && frequency_q12 == 32'd0, sky == SKY_ZERO_Q8)

endmodule

// ===== rtl/alfm_div.sv =====
// restoring divider, one quotient bit per cycle
// uses alfm_pkg for the status struct
module alfm_div
  import alfm_pkg::*;
#(
  parameter int DW = 45,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output div_status_t   status
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= VW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[VW-1:0];
        end
        quo <= {quo[DW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

`include "autorange_light_frequency_meter_defines.svh"

  `ALFM_ASSERT_IMP(a_done_idle, done, !busy)
  `ALFM_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `ALFM_ASSERT_IMP(a_busy_cnt, busy, cnt != '0)

endmodule

// ===== tb/autorange_light_frequency_meter_test.sv =====
// testbench for the auto-ranging light frequency meter: an item-level predictor of
// the meter checks every result item under random valid/ready idling on both channels
// depends on alfm_pkg and the autorange_light_frequency_meter rtl
module autorange_light_frequency_meter_test;
  import alfm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PER_AVG = 11;
  localparam int GATE_AVG = 5;
  localparam int SLOW_MS = 1000;
  localparam int FRAC = 12;
  localparam longint CYCLE_LIMIT = 3000000;
  // command code with no meaning of its own, handled as a poll
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [31:0]        freq;
    logic               seen;
    logic signed [14:0] sky;
    logic               upd;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_CLOCK_HZ;
  logic [27:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_POLL;
  logic [31:0] sample_value = '0;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic range_mode;
  logic [31:0] frequency_q12;
  logic sensor_seen;
  logic signed [14:0] sky_brightness_q8;
  logic frequency_updated;

  autorange_light_frequency_meter u_top (.*);

  // predictor state and configuration
  logic [27:0] c_clock;
  logic [8:0]  c_offset;
  logic [19:0] c_up, c_down;
  logic        m_mode, m_slow, m_seen;
  logic [31:0] m_sum, m_last_ms, m_freq;
  logic [3:0]  m_count;

  reading_t expected_q[$];
  reading_t got, want;
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;
  bit stall_en = 1'b0;
  logic [31:0] t_ms = 32'd5;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("autorange_light_frequency_meter test failed");
      $finish;
    end
  end

  // receiver stall pattern, switched on and off in long stretches
  always @(negedge clk) begin
    if (cycles % 700 == 0) stall_en <= 1'($urandom_range(0, 1));
    out_ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = '{range_mode, frequency_q12, sensor_seen, sky_brightness_q8, frequency_updated};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing expected, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.mode !== want.mode) begin
          errors++;
          $display("%0t: range_mode exp %0d act %0d", $time, want.mode, got.mode);
        end
        if (got.freq !== want.freq) begin
          errors++;
          $display("%0t: frequency_q12 exp %h act %h", $time, want.freq, got.freq);
        end
        if (got.seen !== want.seen) begin
          errors++;
          $display("%0t: sensor_seen exp %0d act %0d", $time, want.seen, got.seen);
        end
        if (got.sky !== want.sky) begin
          errors++;
          $display("%0t: sky_brightness_q8 exp %0d act %0d", $time, want.sky, got.sky);
        end
        if (got.upd !== want.upd) begin
          errors++;
          $display("%0t: frequency_updated exp %0d act %0d", $time, want.upd, got.upd);
        end
      end
    end
  end

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] log2_q16(input logic [31:0] q);
    int e;
    int i;
    logic [31:0] frac;
    logic [63:0] m;
    e = 31;
    frac = '0;
    while (e > 0 && q[e] == 1'b0) e--;
    m = {32'b0, q} << (31 - e);
    for (i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (e << 16) | frac;
  endfunction

  function automatic logic signed [14:0] sky_of_freq();
    longint l, term, off, s;
    longint unsigned mag;
    if (m_freq == 0) return SKY_ZERO_Q8;
    l = longint'(log2_q16(m_freq)) - (longint'(FRAC) << 16);
    mag = (l < 0) ? longint'(-l) : l;
    term = longint'((mag * longint'(LOG_K_Q24) + 64'd2147483648) >> 32);
    if (l < 0) term = -term;
    off = (longint'(c_offset) * 256 + 5) / 10;
    s = off - term;
    if (s > 16383) s = 16383;
    if (s < -16384) s = -16384;
    return s[14:0];
  endfunction

  function automatic void clear_avg();
    m_sum = '0;
    m_count = '0;
  endfunction

  function automatic void add_sample(input logic [31:0] v);
    m_sum = sat32({32'b0, m_sum} + {32'b0, v});
    m_count = m_count + 4'd1;
  endfunction

  function automatic reading_t meter_step(input logic [1:0] cmd, input logic [31:0] val,
                                          input logic [31:0] now);
    logic upd;
    bit check;
    logic [31:0] dt;
    logic [63:0] num;
    upd = 1'b0;
    check = 1'b1;
    if (m_mode == 1'b0) begin
      if (cmd == CMD_PERIOD) begin
        dt = now - m_last_ms;
        m_seen = 1'b1;
        m_last_ms = now;
        if (dt > SLOW_MS) begin
          // slow capture: timer fallback, sample dropped
          m_slow = 1'b1;
          m_freq = sat32(((64'd1000 << FRAC) + dt / 2) / dt);
          upd = 1'b1;
          check = 1'b0;
        end else begin
          if (m_slow) begin
            m_slow = 1'b0;
            clear_avg();
          end
          add_sample(val);
          if (m_count >= PER_AVG) begin
            if (m_sum > 0) begin
              num = ({36'b0, c_clock} * m_count) << FRAC;
              m_freq = sat32((num + m_sum / 2) / m_sum);
            end else begin
              m_freq = '0;
            end
            upd = 1'b1;
            clear_avg();
          end
        end
      end
      if (check && {32'b0, m_freq} > ({44'b0, c_up} << FRAC)) begin
        m_mode = 1'b1;
        clear_avg();
      end
    end else begin
      if (cmd == CMD_GATE) begin
        m_seen = 1'b1;
        add_sample(val);
        if (m_count >= GATE_AVG && m_count > 0) begin
          num = {32'b0, m_sum} << FRAC;
          m_freq = sat32((num + m_count / 2) / m_count);
          upd = 1'b1;
          clear_avg();
        end
      end
      if ({32'b0, m_freq} < ({44'b0, c_down} << FRAC)) begin
        m_mode = 1'b0;
        m_last_ms = now;
        clear_avg();
      end
    end
    return '{m_mode, m_freq, m_seen, sky_of_freq(), upd};
  endfunction

  // caller stands at a falling edge; returns at a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] val,
                           input logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid = 1'b1;
    command = cmd;
    sample_value = val;
    now_ms = now;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(meter_step(cmd, val, now));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [27:0] val);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CLOCK_HZ:    c_clock = val;
      REG_SQ_OFFSET:   c_offset = val[8:0];
      REG_UP_SWITCH:   c_up = val[19:0];
      REG_DOWN_SWITCH: c_down = val[19:0];
      default: ;
    endcase
  endtask

  task automatic capture(input logic [31:0] val, input logic [31:0] dt);
    t_ms = t_ms + dt;
    send_item(CMD_PERIOD, val, t_ms);
  endtask

  task automatic test_directed();
    int i;
    send_item(CMD_POLL, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_UNUSED, 32'h1234_5678, 32'd1);
    send_item(CMD_GATE, 32'd100, 32'd2);          // wrong-mode sample
    for (i = 0; i < PER_AVG; i++) capture(32'd0, 32'd1);   // zero sum
    capture(32'd100, 32'd1001);                   // slow capture
    capture(32'd100, 32'd1000);                   // exactly at the limit
    for (i = 0; i < PER_AVG; i++) capture(32'hFFFF_FFFF, 32'd10); // sum saturates
    t_ms = 32'hFFFF_FFF0;
    send_item(CMD_POLL, 32'd0, t_ms);
    capture(32'd7, 32'hFFFF_FFF0 - m_last_ms);    // long dt
    for (i = 0; i < PER_AVG; i++) capture(32'd1, 32'd8); // wraps, high freq
    send_item(CMD_PERIOD, 32'd5, t_ms);           // capture ignored in gate mode
    for (i = 0; i < GATE_AVG; i++) send_item(CMD_GATE, 32'hFFFF_FFFF, t_ms);
    for (i = 0; i < GATE_AVG; i++) send_item(CMD_GATE, 32'd0, t_ms);
  endtask

  task automatic test_random(input int n);
    int i, r, target, lo, hi;
    logic [31:0] val;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i == n / 2) drain();        // sender waits for every result once
      lo = (c_down > 2) ? c_down / 2 : 1;
      hi = c_up * 2 + 2;
      target = $urandom_range(lo, hi);
      if (r < 8) begin
        t_ms = (r < 2) ? $urandom : t_ms + $urandom_range(0, 3000);
        send_item(2'($urandom_range(0, 3)), $urandom, t_ms);
      end else if (r < 14) begin
        send_item(CMD_POLL, $urandom, t_ms);
      end else if (m_mode == 1'b0) begin
        val = (r < 20) ? $urandom : c_clock / target;
        capture(val, (r < 17) ? $urandom_range(1001, 4000) : $urandom_range(0, 1000));
      end else begin
        t_ms = t_ms + 1000;
        send_item(CMD_GATE, (r < 20) ? $urandom : target, t_ms);
      end
    end
  endtask

  task automatic test_config_sweep();
    write_reg(REG_SQ_OFFSET, 28'd400);
    test_random(300);
    write_reg(REG_CLOCK_HZ, 28'd200000000);
    write_reg(REG_UP_SWITCH, 28'd1000000);
    write_reg(REG_DOWN_SWITCH, 28'd1000000);
    write_reg(REG_SQ_OFFSET, 28'd511);
    test_random(300);
    write_reg(REG_CLOCK_HZ, 28'd1);
    write_reg(REG_UP_SWITCH, 28'd1);
    write_reg(REG_DOWN_SWITCH, 28'd1);
    write_reg(REG_SQ_OFFSET, 28'd0);
    test_random(250);
    write_reg(REG_CLOCK_HZ, 28'd0);              // zero clock
    test_random(150);
    write_reg(REG_CLOCK_HZ, 28'hFFF_FFFF);
    write_reg(REG_UP_SWITCH, 28'hF_FFFF);
    write_reg(REG_DOWN_SWITCH, 28'd3000);
    write_reg(REG_SQ_OFFSET, 28'd215);
    test_random(300);
  endtask

  initial begin
    c_clock = CLOCK_HZ_RST;
    c_offset = '0;
    c_up = UP_SWITCH_RST;
    c_down = DOWN_SWITCH_RST;
    m_mode = 1'b0;
    m_slow = 1'b0;
    m_seen = 1'b0;
    m_sum = '0;
    m_count = '0;
    m_last_ms = '0;
    m_freq = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(450);
    test_config_sweep();
    drain();
    if (errors == 0) begin
      $display("autorange_light_frequency_meter test passed");
    end else begin
      $display("autorange_light_frequency_meter test failed");
    end
    $finish;
  end

endmodule
